[src/nsst_pkg.sv]
// Shared constants and types for the non-separable secondary transform.
`default_nettype none

package nsst_pkg;

  // Region and matrix geometry
  localparam int unsigned MAX_SIDE = 8;
  localparam int unsigned MAX_DIM  = 64;
  localparam int unsigned SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int unsigned DIM_W    = $clog2(MAX_DIM + 1);
  localparam int unsigned IDX_W    = $clog2(MAX_DIM);
  localparam int unsigned MADDR_W  = $clog2(MAX_DIM * MAX_DIM);

  // Port widths fixed by the interface
  localparam int unsigned MIDX_W   = 12;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned RES_W    = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CIDX_W   = 2;

  // Arithmetic: products are accumulated unscaled; the x32 input scale
  // and the 2^14 rounding term fold into a rounding term of 2^9 and a
  // final arithmetic shift by 10.
  localparam int unsigned PROD_W   = 2 * COEF_W;
  localparam int unsigned ACC_W    = PROD_W + IDX_W + 1;
  localparam int unsigned OUT_SH   = 10;
  localparam int unsigned ROUND_C  = 512;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_HEIGHT  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WIDTH   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_INVERSE = 2'd2;

  // Request action codes
  localparam logic ACT_MATRIX = 1'b0;
  localparam logic ACT_COEFF  = 1'b1;

  // One multiply-accumulate step issued by the sequencer
  typedef struct packed {
    logic               valid;
    logic               first;     // first product of an output
    logic               last;      // last product of an output
    logic               blk_last;  // last product of the block
    logic [IDX_W-1:0]   pos;       // output index
    logic [MADDR_W-1:0] maddr;     // matrix entry to read
    logic [IDX_W-1:0]   xaddr;     // stored coefficient to read
  } issue_t;

  // Write into one of the stores
  typedef struct packed {
    logic               m_we;
    logic [MADDR_W-1:0] m_addr;
    logic [COEF_W-1:0]  m_data;
    logic               x_we;
    logic [IDX_W-1:0]   x_addr;
    logic [COEF_W-1:0]  x_data;
  } store_wr_t;

endpackage

`default_nettype wire

[src/nsst_datapath.sv]
// Matrix and coefficient stores with the multiply-accumulate pipeline.
`default_nettype none

module nsst_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire nsst_pkg::store_wr_t         wr_i,
  input  wire nsst_pkg::issue_t            iss_i,
  output logic                             res_valid_o,
  output logic signed [nsst_pkg::RES_W-1:0] res_value_o,
  output logic [nsst_pkg::POS_W-1:0]       res_pos_o,
  output logic                             res_last_o
);
  import nsst_pkg::*;

  logic signed [COEF_W-1:0] mat_mem [MAX_DIM*MAX_DIM];
  logic signed [COEF_W-1:0] x_mem   [MAX_DIM];

  logic signed [COEF_W-1:0] m_rd_q, x_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  issue_t                   s1_q, s2_q;

  logic signed [RES_W-1:0]  res_value_q;
  logic [POS_W-1:0]         res_pos_q;
  logic                     res_valid_q, res_last_q;

  // Matrix store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.m_we) begin
      mat_mem[wr_i.m_addr] <= wr_i.m_data;
    end
    m_rd_q <= mat_mem[iss_i.maddr];
  end

  // Coefficient store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.x_we) begin
      x_mem[wr_i.x_addr] <= wr_i.x_data;
    end
    x_rd_q <= x_mem[iss_i.xaddr];
  end

  // Carry step control alongside the read and multiply stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= iss_i;
      s2_q <= s1_q;
    end
  end

  // Multiply the fetched pair
  always_ff @(posedge clk_i) begin
    prod_q <= m_rd_q * x_rd_q;
  end

  // Accumulate; seed each output with the rounding term
  always_comb begin
    if (s2_q.first) begin
      acc_d = ACC_W'(ROUND_C) + ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  // Finish an output: the shifted sum always fits in 32 bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
    end else begin
      res_valid_q <= s2_q.valid & s2_q.last;
      res_last_q  <= s2_q.valid & s2_q.blk_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q.valid && s2_q.last) begin
      res_value_q <= {{(RES_W-(ACC_W-OUT_SH)){acc_d[ACC_W-1]}}, acc_d[ACC_W-1:OUT_SH]};
      res_pos_q   <= POS_W'(s2_q.pos);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_value_o = res_value_q;
  assign res_pos_o   = res_pos_q;
  assign res_last_o  = res_last_q;

endmodule

`default_nettype wire

[src/nonsep_secondary_transform.sv]
// Top level: request handling, configuration and the product sequencer.
//
// Requests are taken with start_i while busy_o is low. A matrix write or a
// coefficient that does not complete the region leaves busy_o low. The
// coefficient that completes a region of dim = height*width entries starts
// the transform: one multiplier walks all dim*dim matrix entries, one per
// cycle through the single read port of the matrix store, and the results
// come out one by one, each strobed by result_valid_o for one cycle.
// busy_o stays high after that request until the last result of the block
// is shown. Results cannot be held off; the receiver must take each one in
// the cycle it is shown. The stores have no reset: only matrix entries that
// were written may be used by a transform.
`default_nettype none

module nonsep_secondary_transform (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration writes
  input  wire logic                           cfg_we_i,
  input  wire logic [nsst_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  wire logic [nsst_pkg::CFG_W-1:0]     cfg_data_i,
  // Requests
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic                           action_i,
  input  wire logic [nsst_pkg::MIDX_W-1:0]    matrix_index_i,
  input  wire logic signed [nsst_pkg::COEF_W-1:0] matrix_value_i,
  input  wire logic signed [nsst_pkg::COEF_W-1:0] coeff_value_i,
  // Results
  output logic                                result_valid_o,
  output logic signed [nsst_pkg::RES_W-1:0]   result_value_o,
  output logic [nsst_pkg::POS_W-1:0]          result_position_o,
  output logic                                last_of_block_o
);
  import nsst_pkg::*;

  logic [SIDE_W-1:0]   height_q, width_q;
  logic                inverse_q;

  logic [SIDE_W-1:0]   height_c, width_c;
  logic [2*SIDE_W-1:0] dim_prod;
  logic [DIM_W-1:0]    dim_cur, dim_q, dim_m1;

  logic [IDX_W-1:0]    count_q, count_d;
  logic [DIM_W-1:0]    count_inc;
  logic                busy_q, busy_d;
  logic                run_q, run_d;
  logic [IDX_W-1:0]    a_q, a_d, b_q, b_d;
  logic [MADDR_W-1:0]  addr_q, addr_d;

  logic                accept, coeff_acc, block_done;
  issue_t              iss;
  store_wr_t           wr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q  <= SIDE_W'(MAX_SIDE);
      width_q   <= SIDE_W'(MAX_SIDE);
      inverse_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEIGHT:  height_q  <= cfg_data_i[SIDE_W-1:0];
        REG_WIDTH:   width_q   <= cfg_data_i[SIDE_W-1:0];
        REG_INVERSE: inverse_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the region sides and form the region size
  always_comb begin
    if (height_q == '0) begin
      height_c = SIDE_W'(1);
    end else if (height_q > SIDE_W'(MAX_SIDE)) begin
      height_c = SIDE_W'(MAX_SIDE);
    end else begin
      height_c = height_q;
    end
    if (width_q == '0) begin
      width_c = SIDE_W'(1);
    end else if (width_q > SIDE_W'(MAX_SIDE)) begin
      width_c = SIDE_W'(MAX_SIDE);
    end else begin
      width_c = width_q;
    end
    dim_prod = height_c * width_c;
    dim_cur  = dim_prod[DIM_W-1:0];
  end

  assign accept     = start_i & ~busy_q;
  assign coeff_acc  = accept & (action_i == ACT_COEFF);
  assign count_inc  = DIM_W'(count_q) + DIM_W'(1);
  assign dim_m1     = dim_q - DIM_W'(1);
  assign block_done = result_valid_o & last_of_block_o;

  // Route accepted requests into the stores
  always_comb begin
    wr        = '0;
    wr.m_we   = accept && (action_i == ACT_MATRIX) &&
                (32'(matrix_index_i) < MAX_DIM * MAX_DIM);
    wr.m_addr = MADDR_W'(matrix_index_i);
    wr.m_data = matrix_value_i;
    wr.x_we   = coeff_acc;
    wr.x_addr = count_q;
    wr.x_data = coeff_value_i;
  end

  // Current multiply-accumulate step
  always_comb begin
    iss          = '0;
    iss.valid    = run_q;
    iss.first    = (b_q == '0);
    iss.last     = (DIM_W'(b_q) == dim_m1);
    iss.blk_last = iss.last && (DIM_W'(a_q) == dim_m1);
    iss.pos      = a_q;
    iss.maddr    = addr_q;
    iss.xaddr    = b_q;
  end

  // Count coefficients, start the block, walk the matrix
  always_comb begin
    count_d = count_q;
    busy_d  = busy_q;
    run_d   = run_q;
    a_d     = a_q;
    b_d     = b_q;
    addr_d  = addr_q;
    if (coeff_acc) begin
      if (count_inc >= dim_cur) begin
        count_d = '0;
        busy_d  = 1'b1;
        run_d   = 1'b1;
        a_d     = '0;
        b_d     = '0;
        addr_d  = '0;
      end else begin
        count_d = count_inc[IDX_W-1:0];
      end
    end
    if (run_q) begin
      if (iss.last) begin
        b_d = '0;
        a_d = a_q + IDX_W'(1);
        if (inverse_q) begin
          addr_d = MADDR_W'(a_q) + MADDR_W'(1);
        end else begin
          addr_d = addr_q + MADDR_W'(1);
        end
        if (iss.blk_last) begin
          run_d = 1'b0;
        end
      end else begin
        b_d = b_q + IDX_W'(1);
        if (inverse_q) begin
          addr_d = addr_q + MADDR_W'(dim_q);
        end else begin
          addr_d = addr_q + MADDR_W'(1);
        end
      end
    end
    if (block_done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
      run_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
      run_q   <= run_d;
    end
  end

  // Walk position and region size of the running block
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    addr_q <= addr_d;
    if (coeff_acc && (count_inc >= dim_cur)) begin
      dim_q <= dim_cur;
    end
  end

  nsst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .iss_i       (iss),
    .res_valid_o (result_valid_o),
    .res_value_o (result_value_o),
    .res_pos_o   (result_position_o),
    .res_last_o  (last_of_block_o)
  );

  assign busy_o = busy_q;

  // Results only appear while a block is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe outside a block");

  // The sequencer only runs inside a busy window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> busy_q)
    else $error("sequencer running while idle");

  // The final result of a block releases the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_of_block_o) |=> !busy_o)
    else $error("busy held after last result");

  // Results within a block are never shown back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_of_block_o) |=> !result_valid_o)
    else $error("back-to-back results within a block");

endmodule

`default_nettype wire
